// ----- src/wrd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wide restoring divider package
// Shared widths, channel payload types and the controller/datapath interface.
// ----------------------------------------------------------------------------
package wrd_pkg;

   localparam int WORD_W  = 64;
   localparam int VALUE_W = 2 * WORD_W;
   localparam int LZ_W    = $clog2(VALUE_W);
   localparam int STEP_W  = LZ_W + 1;

   // Largest leading-zero count; a zero value is treated as having its msb at bit 0.
   localparam logic [LZ_W-1:0] LZ_MAX = LZ_W'(VALUE_W - 1);

   typedef struct packed {
      logic [WORD_W-1:0] dividend_low;
      logic [WORD_W-1:0] dividend_high;
      logic [WORD_W-1:0] divisor_low;
      logic [WORD_W-1:0] divisor_high;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] quotient_low;
      logic [WORD_W-1:0] quotient_high;
      logic [WORD_W-1:0] remainder_low;
      logic [WORD_W-1:0] remainder_high;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic norm;
      logic align;
      logic step;
   } wrd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic              norm_done;
      logic              n_ge_d;
      logic [STEP_W-1:0] step_count;
   } wrd_status_type;

endpackage
`default_nettype wire

// ----- src/wrd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wide restoring divider datapath
// Leading-zero normalization, divisor alignment and the compare-subtract-shift
// step of restoring division, all under command of the controller.
// ----------------------------------------------------------------------------
module wrd_datapath (
   input  wire                    clock,
   input  wrd_pkg::wrd_cmd_type   cmd,
   input  wrd_pkg::req_type       req_data,
   output wrd_pkg::wrd_status_type status,
   output wrd_pkg::rsp_type       rsp_data
);
   import wrd_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [LZ_W-1:0]    count;
      logic               done;
   } norm_type;

   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [VALUE_W-1:0] div_ff, div_in;
   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [VALUE_W-1:0] tn_ff, td_ff;
   logic [LZ_W-1:0]    lzn_ff, lzd_ff;
   logic [VALUE_W:0]   diff;
   logic               fits;
   logic [LZ_W-1:0]    shift;
   norm_type           norm_n, norm_d;

   // One normalization step: shift left by 16, 4 or 1 while the top bits are
   // zero, never counting past the largest leading-zero count.
   function automatic norm_type norm_step(input logic [VALUE_W-1:0] value,
                                          input logic [LZ_W-1:0] count);
      norm_type r;
      r.value = value;
      r.count = count;
      r.done  = 1'b0;
      if (value[VALUE_W-1 -: 16] == '0 && count <= LZ_MAX - LZ_W'(16)) begin
         r.value = value << 16;
         r.count = count + LZ_W'(16);
      end else if (value[VALUE_W-1 -: 4] == '0 && count <= LZ_MAX - LZ_W'(4)) begin
         r.value = value << 4;
         r.count = count + LZ_W'(4);
      end else if (!value[VALUE_W-1] && count != LZ_MAX) begin
         r.value = value << 1;
         r.count = count + LZ_W'(1);
      end else begin
         r.done = 1'b1;
      end
      return r;
   endfunction

   assign norm_n = norm_step(tn_ff, lzn_ff);
   assign norm_d = norm_step(td_ff, lzd_ff);

   // Normalization registers count leading zeros of both operands.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tn_ff  <= {req_data.dividend_high, req_data.dividend_low};
         td_ff  <= {req_data.divisor_high, req_data.divisor_low};
         lzn_ff <= '0;
         lzd_ff <= '0;
      end else if (cmd.norm) begin
         tn_ff  <= norm_n.value;
         lzn_ff <= norm_n.count;
         td_ff  <= norm_d.value;
         lzd_ff <= norm_d.count;
      end
   end

   // Compare and subtract of the current step.
   assign diff  = {1'b0, rem_ff} - {1'b0, div_ff};
   assign fits  = !diff[VALUE_W];
   assign shift = lzd_ff - lzn_ff;

   // Next values of remainder, aligned divisor and quotient.
   always_comb begin
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      if (cmd.load) begin
         rem_in = {req_data.dividend_high, req_data.dividend_low};
         quo_in = '0;
      end else if (cmd.align) begin
         // td holds the divisor shifted up by lzd; back off by lzn to align msbs.
         div_in = td_ff >> lzn_ff;
      end else if (cmd.step) begin
         if (fits) begin
            rem_in = diff[VALUE_W-1:0];
         end
         quo_in = {quo_ff[VALUE_W-2:0], fits};
         div_in = div_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   // Status back to the controller.
   assign status.norm_done  = norm_n.done && norm_d.done;
   assign status.n_ge_d     = lzn_ff <= lzd_ff;
   assign status.step_count = {1'b0, shift} + STEP_W'(1);

   assign rsp_data.quotient_low   = quo_ff[WORD_W-1:0];
   assign rsp_data.quotient_high  = quo_ff[VALUE_W-1:WORD_W];
   assign rsp_data.remainder_low  = rem_ff[WORD_W-1:0];
   assign rsp_data.remainder_high = rem_ff[VALUE_W-1:WORD_W];

endmodule
`default_nettype wire

// ----- src/wrd_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wide restoring divider controller
// Sequences load, normalization, alignment, the division steps and the
// result handshake.
// ----------------------------------------------------------------------------
module wrd_controller (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   input  wrd_pkg::wrd_status_type status,
   output wrd_pkg::wrd_cmd_type    cmd
);
   import wrd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_ALIGN,
      ST_STEP,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] steps_ff;

   // State register and step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         steps_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               if (status.norm_done) begin
                  state_ff <= ST_ALIGN;
               end
            end
            ST_ALIGN: begin
               if (status.n_ge_d) begin
                  steps_ff <= status.step_count;
                  state_ff <= ST_STEP;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_STEP: begin
               steps_ff <= steps_ff - STEP_W'(1);
               if (steps_ff == STEP_W'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Commands and handshake outputs decode from the state.
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_DONE;
   assign cmd.load  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.norm  = (state_ff == ST_NORM) && !status.norm_done;
   assign cmd.align = (state_ff == ST_ALIGN);
   assign cmd.step  = (state_ff == ST_STEP);

endmodule
`default_nettype wire

// ----- src/wide_restoring_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wide restoring divider
// Unsigned 128-bit division giving quotient and remainder.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req_data) carries the dividend
// and divisor as 64-bit halves; the response channel (rsp_valid, rsp_stall,
// rsp_data) returns quotient and remainder the same way. A request is taken
// when valid is high and stall is low at a rising clock edge.
// One request is worked on at a time: req_stall stays high from acceptance
// until its response has been taken. After acceptance the block counts
// leading zeros of both operands (16, 4 or 1 bits a cycle), aligns the
// divisor, then runs msb difference plus one steps of compare-subtract-shift
// on the 128-bit subtractor, at most 128. The response is presented in the
// cycle that follows the last step, or alignment when no steps run.
// If the dividend's msb lies below the divisor's, no steps are run.
// A zero divisor is not flagged; each quotient bit from the dividend's msb
// down is set and the remainder equals the dividend.
// The response holds steady while rsp_stall is high. Synchronous reset
// returns the controller to idle and drops any division in progress.
// ----------------------------------------------------------------------------
module wide_restoring_divider (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wrd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output wrd_pkg::rsp_type  rsp_data
);
   import wrd_pkg::*;

   wrd_cmd_type    cmd;
   wrd_status_type status;

   // Sequencing.
   wrd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic.
   wrd_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ----- verif/wide_restoring_divider_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wide restoring divider testbench
// Drives 128-bit unsigned division requests through the request channel and
// checks every quotient and remainder against a typed answer or a behavioral
// divider. A short table of directed cases covers zero and all-ones operands,
// a zero divisor, a dividend below the divisor and equal operands. About a
// thousand random requests follow. Both channels idle at random, and one long
// receiver hold-off backs the block up into its request channel.
// ----------------------------------------------------------------------------
module wide_restoring_divider_test;
   import wrd_pkg::*;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TOP_ONE = 64'h8000_0000_0000_0000;
   localparam int RANDOM_REQUESTS = 1000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES = 200;
   localparam int DIRECTED_ROWS = 20;

   // One directed case; the expected words are used only when known is set.
   typedef struct packed {
      logic [63:0] dividend_low;
      logic [63:0] dividend_high;
      logic [63:0] divisor_low;
      logic [63:0] divisor_high;
      logic        known;
      logic [63:0] quotient_low;
      logic [63:0] quotient_high;
      logic [63:0] remainder_low;
      logic [63:0] remainder_high;
   } directed_row_type;

   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      // Zero over zero gives a quotient of one.
      '{64'd0, 64'd0, 64'd0, 64'd0, 1'b1, 64'd1, 64'd0, 64'd0, 64'd0},
      // Zero divisor sets every quotient bit up to the dividend's msb.
      '{64'd5, 64'd0, 64'd0, 64'd0, 1'b1, 64'd7, 64'd0, 64'd5, 64'd0},
      '{ALL_ONES, ALL_ONES, 64'd0, 64'd0, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES},
      '{64'd12345, 64'd0, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0},
      // Largest dividend over one runs all 128 steps.
      '{ALL_ONES, ALL_ONES, 64'd1, 64'd0, 1'b1, ALL_ONES, ALL_ONES, 64'd0, 64'd0},
      '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 64'd1, 64'd0, 64'd0, 64'd0},
      '{64'd0, 64'd0, ALL_ONES, ALL_ONES, 1'b1, 64'd0, 64'd0, 64'd0, 64'd0},
      // Dividend msb below the divisor msb: no steps at all.
      '{64'd3, 64'd0, 64'd0, 64'h0000_0010_0000_0000, 1'b1, 64'd0, 64'd0, 64'd3, 64'd0},
      '{64'd7, 64'd0, 64'd100, 64'd0, 1'b1, 64'd0, 64'd0, 64'd7, 64'd0},
      '{ALL_ONES, 64'd0, ALL_ONES, ALL_ONES, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0},
      '{64'd0, 64'd1, 64'd1, 64'd0, 1'b1, 64'd0, 64'd1, 64'd0, 64'd0},
      '{64'd100, 64'd0, 64'd7, 64'd0, 1'b1, 64'd14, 64'd0, 64'd2, 64'd0},
      '{64'd1, 64'd0, 64'd1, 64'd0, 1'b1, 64'd1, 64'd0, 64'd0, 64'd0},
      // Same msb but the dividend is smaller.
      '{64'd5, 64'd0, 64'd6, 64'd0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0},
      '{64'd0, TOP_ONE, 64'd0, 64'd1, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0},
      '{ALL_ONES, ALL_ONES, 64'd0, TOP_ONE, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0},
      '{64'd0, ALL_ONES, ALL_ONES, 64'd0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0},
      '{TOP_ONE, 64'd0, 64'd3, 64'd0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0},
      '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'h0F0F_0F0F_0F0F_0F0F,
        64'd0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0},
      '{ALL_ONES, 64'h7FFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0}
   };

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_divisions [$];
   int      error_count = 0;
   bit      steady_flow = 1'b0;
   bit      start_hold_off = 1'b0;

   wide_restoring_divider uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #12_000_000;
      $display("wide_restoring_divider verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // Index of the highest set bit; a zero value counts as bit 0.
   function automatic int top_bit(input logic [127:0] value);
      int pos;
      pos = 0;
      for (int k = 0; k < 128; k++) begin
         if (value[k]) begin
            pos = k;
         end
      end
      return pos;
   endfunction

   // Restoring division exactly as the block performs it, zero divisor included.
   function automatic rsp_type divide_128(input req_type request);
      logic [127:0] remainder;
      logic [127:0] aligned;
      logic [127:0] quotient;
      int           msb_dividend;
      int           msb_divisor;
      int           shift;
      rsp_type      result;
      remainder = {request.dividend_high, request.dividend_low};
      aligned = {request.divisor_high, request.divisor_low};
      quotient = '0;
      msb_dividend = top_bit(remainder);
      msb_divisor = top_bit(aligned);
      if (msb_dividend >= msb_divisor) begin
         shift = msb_dividend - msb_divisor;
         aligned = aligned << shift;
         for (int bit_index = shift; bit_index >= 0; bit_index--) begin
            if (remainder >= aligned) begin
               quotient[bit_index] = 1'b1;
               remainder = remainder - aligned;
            end
            aligned = aligned >> 1;
         end
      end
      result.quotient_low = quotient[63:0];
      result.quotient_high = quotient[127:64];
      result.remainder_low = remainder[63:0];
      result.remainder_high = remainder[127:64];
      return result;
   endfunction

   // Random value of the given bit length with its top bit set.
   function automatic logic [127:0] random_value(input int unsigned width);
      logic [127:0] value;
      value = {$urandom, $urandom, $urandom, $urandom};
      if (width == 0) begin
         return '0;
      end
      value = value & ((128'd1 << width) - 128'd1);
      value[width-1] = 1'b1;
      return value;
   endfunction

   // Mix of operand shapes: zero divisor, equal or nearby operands, short
   // divisors for long step runs, and full-width noise.
   function automatic req_type random_request();
      logic [127:0] dividend;
      logic [127:0] divisor;
      int unsigned  pick;
      req_type      request;
      pick = $urandom_range(99);
      dividend = random_value($urandom_range(128));
      if (pick < 8) begin
         divisor = '0;
      end else if (pick < 14) begin
         divisor = dividend;
      end else if (pick < 20) begin
         divisor = dividend + 128'($urandom_range(4)) - 128'd2;
      end else if (pick < 32) begin
         dividend = {$urandom, $urandom, $urandom, $urandom};
         divisor = {$urandom, $urandom, $urandom, $urandom};
      end else if (pick < 45) begin
         divisor = random_value($urandom_range(16));
      end else begin
         divisor = random_value($urandom_range(128));
      end
      request.dividend_low = dividend[63:0];
      request.dividend_high = dividend[127:64];
      request.divisor_low = divisor[63:0];
      request.divisor_high = divisor[127:64];
      return request;
   endfunction

   // Offer one request after a random gap and hold it until it is taken.
   task automatic send_request(input req_type request, input rsp_type expected);
      while (!steady_flow && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= request;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_divisions.push_back(expected);
   endtask

   // Receiver: random stalls, one long hold-off, and none while flow is steady.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (start_hold_off) begin
            start_hold_off = 1'b0;
            hold_left = HOLD_OFF_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady_flow && ($urandom_range(99) < 30);
         end
      end
   end

   task automatic compare_word(input string field, input logic [63:0] got,
                               input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h, want %h", field, got, want));
      end
   endtask

   // Compare every taken response with the oldest pending expectation.
   always @(posedge clock) begin : check_response
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_divisions.size() == 0) begin
            report_mismatch("response arrived with no request pending");
         end else begin
            want = expected_divisions.pop_front();
            compare_word("quotient_low", rsp_data.quotient_low, want.quotient_low);
            compare_word("quotient_high", rsp_data.quotient_high, want.quotient_high);
            compare_word("remainder_low", rsp_data.remainder_low, want.remainder_low);
            compare_word("remainder_high", rsp_data.remainder_high, want.remainder_high);
         end
      end
   end

   initial begin : stimulus
      req_type          request;
      rsp_type          typed;
      directed_row_type row;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table; rows without a typed answer use the behavioral divider.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED_TABLE[r];
         request.dividend_low = row.dividend_low;
         request.dividend_high = row.dividend_high;
         request.divisor_low = row.divisor_low;
         request.divisor_high = row.divisor_high;
         typed.quotient_low = row.quotient_low;
         typed.quotient_high = row.quotient_high;
         typed.remainder_low = row.remainder_low;
         typed.remainder_high = row.remainder_high;
         send_request(request, row.known ? typed : divide_128(request));
      end

      // Random requests, with a steady stretch and one receiver hold-off.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 150) begin
            start_hold_off = 1'b1;
         end
         steady_flow = (n >= 400) && (n < 600);
         request = random_request();
         send_request(request, divide_128(request));
      end
      steady_flow = 1'b0;
      req_valid <= 1'b0;

      while (expected_divisions.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("wide_restoring_divider verification clean");
      end else begin
         $display("wide_restoring_divider verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
